// File: sv/tqv_pkg.sv
// Package for the tile quad vertex generator.
// Holds the sequencer state type, register indexes, field widths and corner tables.
// No dependencies.
package tqv_pkg;

  // Field widths
  localparam int unsigned TileNumW = 16;
  localparam int unsigned RotW     = 2;
  localparam int unsigned PosW     = 26;
  localparam int unsigned TexW     = 20;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned CntW     = 12;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 13;

  // Serial step count: one quotient or multiplier bit per cycle
  localparam int unsigned SerialSteps = 16;
  localparam int unsigned StepCntW    = 4;

  // Largest placement count the column and row counters hold
  localparam int unsigned CounterLimit = 4096;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] RegMapWidth   = 4'd0;
  localparam logic [CfgAddrW-1:0] RegTileWidth  = 4'd1;
  localparam logic [CfgAddrW-1:0] RegTileHeight = 4'd2;
  localparam logic [CfgAddrW-1:0] RegAtlasCols  = 4'd3;
  localparam logic [CfgAddrW-1:0] RegPadX       = 4'd4;
  localparam logic [CfgAddrW-1:0] RegPadY       = 4'd5;
  localparam logic [CfgAddrW-1:0] RegMarginX    = 4'd6;
  localparam logic [CfgAddrW-1:0] RegMarginY    = 4'd7;

  localparam logic [SlotW-1:0] LastSlot = 3'd5;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StDivide = 5'b00010,
    StMult   = 5'b00100,
    StCorner = 5'b01000,
    StEmit   = 5'b10000
  } state_e;

  // Corner code: bit 0 selects the right edge, bit 1 the bottom edge
  function automatic logic [1:0] pos_corner(input logic [SlotW-1:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Texture corner order per rotation code
  function automatic logic [1:0] tex_corner(input logic [RotW-1:0] rot,
                                            input logic [SlotW-1:0] slot);
    logic [1:0] c;
    logic [1:0] p;
    p = pos_corner(slot);
    case (rot)
      2'd0:    c = p;
      // ninety anticlockwise: TL<-BL, TR<-TL, BL<-BR, BR<-TR
      2'd1:    c = (p == 2'd0) ? 2'd2 : (p == 2'd1) ? 2'd0 : (p == 2'd2) ? 2'd3 : 2'd1;
      // one-eighty: diagonal swap
      2'd2:    c = ~p;
      // ninety clockwise
      default: c = (p == 2'd0) ? 2'd1 : (p == 2'd1) ? 2'd3 : (p == 2'd2) ? 2'd0 : 2'd2;
    endcase
    return c;
  endfunction

endpackage

// File: sv/tile_quad_vertex_generator.sv
// Tile quad vertex generator top level.
// Depends on tqv_pkg for the state type, register indexes and corner tables.
// Bit-serial divider and multipliers feed a six-vertex output sequencer.

// Each accepted tile passes through the restoring divider (one quotient bit per
// cycle splits the tile number into atlas row and column), four bit-serial
// shift-add multipliers that run side by side (screen x, screen y, atlas u,
// atlas v), a corner state that forms the rectangle corners, the hand-out of the
// six vertices and an idle state in which the next tile is taken. The next tile
// can be taken in the cycle after the sixth vertex enters the output register,
// even while that vertex still waits there. Configuration writes are always
// ready and must only happen while no tile is in flight.
module tile_quad_vertex_generator
  import tqv_pkg::*;
#(
  parameter int SEAM_OVERLAP_SIXTEENTHS = 0,
  parameter int MAX_ROWS                = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input tiles
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // tile_number[15:0], rotation[17:16], zero pad
  input  logic [0:0]          s_axis_tuser,   // first_tile[0]
  // Output vertices
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [95:0]         m_axis_tdata,   // pos_x[25:0], pos_y[51:26], tex_u[71:52],
                                              // tex_v[91:72], vertex_slot[94:92], zero pad
  output logic                m_axis_tlast,   // last
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Row bound clamped to the counter range
  localparam int RowLimitInt = (MAX_ROWS > CounterLimit) ? CounterLimit :
                               ((MAX_ROWS < 1) ? 1 : MAX_ROWS);
  localparam logic [CntW:0]   RowLimit = (CntW+1)'(RowLimitInt);
  localparam logic [PosW-1:0] Seam     = PosW'(SEAM_OVERLAP_SIXTEENTHS);

  // Configuration registers
  logic [12:0] map_width_q;
  logic [8:0]  tile_w_q, tile_h_q;
  logic [10:0] atlas_cols_q;
  logic [7:0]  pad_x_q, pad_y_q, margin_x_q, margin_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 13'd1;
      tile_w_q     <= 9'd16;
      tile_h_q     <= 9'd16;
      atlas_cols_q <= 11'd1;
      pad_x_q      <= '0;
      pad_y_q      <= '0;
      margin_x_q   <= '0;
      margin_y_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegMapWidth:   map_width_q  <= cfg_data_i;
        RegTileWidth:  tile_w_q     <= cfg_data_i[8:0];
        RegTileHeight: tile_h_q     <= cfg_data_i[8:0];
        RegAtlasCols:  atlas_cols_q <= cfg_data_i[10:0];
        RegPadX:       pad_x_q      <= cfg_data_i[7:0];
        RegPadY:       pad_y_q      <= cfg_data_i[7:0];
        RegMarginX:    margin_x_q   <= cfg_data_i[7:0];
        RegMarginY:    margin_y_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective map width and atlas column count
  logic [12:0] width_eff;
  logic [10:0] cols_eff;
  always_comb begin
    width_eff = (map_width_q == '0) ? 13'd1 : map_width_q;
    if (width_eff > 13'(CounterLimit)) width_eff = 13'(CounterLimit);
    cols_eff = (atlas_cols_q == '0) ? 11'd1 : atlas_cols_q;
  end

  state_e state_q, state_d;
  logic   in_acc, out_load;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Placement counters: clear on first tile, wrap column, saturate row
  logic [CntW-1:0] col_q, row_q, col_cur, row_cur, col_d, row_d;
  always_comb begin
    col_cur = s_axis_tuser[0] ? '0 : col_q;
    row_cur = s_axis_tuser[0] ? '0 : row_q;
    col_d   = col_cur + 1'b1;
    row_d   = row_cur;
    if ({1'b0, col_cur} + 1'b1 >= width_eff) begin
      col_d = '0;
      if ({1'b0, row_cur} + 1'b1 < RowLimit) row_d = row_cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Step counter for the serial phases
  logic [StepCntW-1:0] step_q;
  logic                step_end;
  assign step_end = (step_q == StepCntW'(SerialSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == StDivide || state_q == StMult) begin
      step_q <= step_q + 1'b1;
    end else begin
      step_q <= '0;
    end
  end

  // Restoring divider: dividend shifts out, quotient shifts in
  logic [TileNumW-1:0] quo_q;
  logic [10:0]         rem_q;
  logic [11:0]         rem_sh;
  logic                rem_ge;
  logic [RotW-1:0]     rot_q;

  assign rem_sh = {rem_q, quo_q[TileNumW-1]};
  assign rem_ge = (rem_sh >= {1'b0, cols_eff});

  // Serial multipliers, MSB first: acc = 2*acc + bit*multiplicand
  logic [15:0] mr_x_q, mr_y_q, mr_u_q;
  logic [20:0] acc_x_q, acc_y_q, acc_u_q;
  logic [25:0] acc_v_q;
  logic [9:0]  step_u, step_v;

  assign step_u = {1'b0, tile_w_q} + {2'b0, pad_x_q};
  assign step_v = {1'b0, tile_h_q} + {2'b0, pad_y_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      quo_q  <= s_axis_tdata[TileNumW-1:0];
      rot_q  <= s_axis_tdata[TileNumW +: RotW];
      rem_q  <= '0;
      mr_x_q <= 16'(col_cur);
      mr_y_q <= 16'(row_cur);
    end else if (state_q == StDivide) begin
      quo_q <= {quo_q[TileNumW-2:0], rem_ge};
      rem_q <= rem_ge ? 11'(rem_sh - {1'b0, cols_eff}) : rem_sh[10:0];
      if (step_end) begin
        mr_u_q  <= 16'(rem_ge ? 11'(rem_sh - {1'b0, cols_eff}) : rem_sh[10:0]);
        acc_x_q <= '0;
        acc_y_q <= '0;
        acc_u_q <= '0;
        acc_v_q <= '0;
      end
    end else if (state_q == StMult) begin
      acc_x_q <= {acc_x_q[19:0], 1'b0} + (mr_x_q[15] ? 21'(tile_w_q) : 21'd0);
      acc_y_q <= {acc_y_q[19:0], 1'b0} + (mr_y_q[15] ? 21'(tile_h_q) : 21'd0);
      acc_u_q <= {acc_u_q[19:0], 1'b0} + (mr_u_q[15] ? 21'(step_u) : 21'd0);
      acc_v_q <= {acc_v_q[24:0], 1'b0} + (quo_q[15] ? 26'(step_v) : 26'd0);
      mr_x_q  <= {mr_x_q[14:0], 1'b0};
      mr_y_q  <= {mr_y_q[14:0], 1'b0};
      mr_u_q  <= {mr_u_q[14:0], 1'b0};
      quo_q   <= {quo_q[14:0], 1'b0};
    end
  end

  // Rectangle corners: seam overlap on screen, saturation in the atlas
  logic [PosW-1:0] px0_q, px1_q, py0_q, py1_q;
  logic [TexW-1:0] tu0_q, tu1_q, tv0_q, tv1_q;
  logic [21:0]     tu0_w, tu1_w, px1_w, py1_w;
  logic [26:0]     tv0_w, tv1_w;

  assign px1_w = {1'b0, acc_x_q} + 22'(tile_w_q);
  assign py1_w = {1'b0, acc_y_q} + 22'(tile_h_q);
  assign tu0_w = {1'b0, acc_u_q} + 22'(margin_x_q);
  assign tu1_w = tu0_w + 22'(tile_w_q);
  assign tv0_w = {1'b0, acc_v_q} + 27'(margin_y_q);
  assign tv1_w = tv0_w + 27'(tile_h_q);

  always_ff @(posedge clk_i) begin
    if (state_q == StCorner) begin
      px0_q <= PosW'({acc_x_q, 4'b0}) - Seam;
      px1_q <= PosW'({px1_w, 4'b0}) + Seam;
      py0_q <= PosW'({acc_y_q, 4'b0}) - Seam;
      py1_q <= PosW'({py1_w, 4'b0}) + Seam;
      tu0_q <= (tu0_w[21:20] != '0) ? '1 : tu0_w[TexW-1:0];
      tu1_q <= (tu1_w[21:20] != '0) ? '1 : tu1_w[TexW-1:0];
      tv0_q <= (tv0_w[26:20] != '0) ? '1 : tv0_w[TexW-1:0];
      tv1_q <= (tv1_w[26:20] != '0) ? '1 : tv1_w[TexW-1:0];
    end
  end

  // Vertex output register
  logic [SlotW-1:0] slot_q;
  logic             out_valid_q, last_q;
  logic [PosW-1:0]  pos_x_q, pos_y_q;
  logic [TexW-1:0]  tex_u_q, tex_v_q;
  logic [SlotW-1:0] out_slot_q;
  logic [1:0]       pc, tc;

  assign out_load = (state_q == StEmit) && (!out_valid_q || m_axis_tready);
  assign pc       = pos_corner(slot_q);
  assign tc       = tex_corner(rot_q, slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q != StEmit) begin
        slot_q <= '0;
      end else if (out_load) begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_q    <= pc[0] ? px1_q : px0_q;
      pos_y_q    <= pc[1] ? py1_q : py0_q;
      tex_u_q    <= tc[0] ? tu1_q : tu0_q;
      tex_v_q    <= tc[1] ? tv1_q : tv0_q;
      out_slot_q <= slot_q;
      last_q     <= (slot_q == LastSlot);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_slot_q, tex_v_q, tex_u_q, pos_y_q, pos_x_q};
  assign m_axis_tlast  = last_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_acc) state_d = StDivide;
      StDivide: if (step_end) state_d = StMult;
      StMult:   if (step_end) state_d = StCorner;
      StCorner: state_d = StEmit;
      StEmit:   if (out_load && slot_q == LastSlot) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} < RowLimit)
    else $error("row counter beyond its bound");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide) |-> (rem_q < cols_eff))
    else $error("divider remainder not below atlas columns");

  a_last_ends_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && slot_q == LastSlot) |=> (state_q == StIdle && m_axis_tlast))
    else $error("sixth vertex did not close the tile");

endmodule
